### hdl/sbbf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbbf_pkg
// shared types and constants for the split block bloom filter
// ----------------------------------------------------------------------------
package sbbf_pkg;

    localparam int MAX_BLOCKS      = 1024;
    localparam int BLK_W           = $clog2(MAX_BLOCKS);
    localparam int CFG_W           = 11;
    localparam int WORDS_PER_BLOCK = 8;
    localparam int ROW_W           = 32 * WORDS_PER_BLOCK;

    localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;
    localparam logic [63:0] GOLDEN = 64'h9e3779b97f4a7c15;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    localparam logic [31:0] SALT [WORDS_PER_BLOCK] = '{
        32'h47b6137b, 32'h44974d91, 32'h8824ad5b, 32'ha2b7289d,
        32'h705495c7, 32'h2df1424b, 32'h9efc4947, 32'h5c6bfb31
    };

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;      // capture input item
        logic stage;     // advance one pipeline step
        logic clr_wr;    // write zero row at clear address
        logic mem_rd;    // read the selected row
        logic mem_wr;    // write back the merged row
        logic out_load;  // capture result
    } sbbf_cmd_t;

    typedef struct packed {
        logic clr_last;
    } sbbf_sts_t;

endpackage
`default_nettype wire

### hdl/sbbf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbbf_ctrl
// controller: clearing pass, then one item through the hash and row steps
// ----------------------------------------------------------------------------
module sbbf_ctrl (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire                   out_ready,
    input  sbbf_pkg::sbbf_sts_t   sts,
    output sbbf_pkg::sbbf_cmd_t   cmd
);
    import sbbf_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_MIX   = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_WRITE = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [2:0] step_reg, step_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    step_next  = '0;
                    state_next = S_MIX;
                end
            end
            S_MIX:
            begin
                // finisher multiplies, block pick and salt multiplies
                cmd.stage = 1'b1;
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd5)
                    state_next = S_READ;
            end
            S_READ:
            begin
                cmd.mem_rd = 1'b1;
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                if (out_free)
                begin
                    cmd.mem_wr     = 1'b1;
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

### hdl/sbbf_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbbf_dpath
// datapath: hash finishers, block pick, mask build, bit store and counter
// ----------------------------------------------------------------------------
module sbbf_dpath (
    input  wire                          clk,
    input  wire                          rst_n,
    input  sbbf_pkg::sbbf_cmd_t          cmd,
    output sbbf_pkg::sbbf_sts_t          sts,
    input  wire [sbbf_pkg::CFG_W-1:0]    blocks_in_use,
    input  wire                          operation,
    input  wire [63:0]                   key_hash,
    output logic                         maybe_present,
    output logic [sbbf_pkg::BLK_W-1:0]   chosen_block,
    output logic [31:0]                  entry_count
);
    import sbbf_pkg::*;

    localparam int NB_W = BLK_W + 1;

    logic [ROW_W-1:0] mem [MAX_BLOCKS];
    logic [BLK_W-1:0] clr_addr_reg;

    logic             op_reg;
    logic [63:0]      a_reg, b_reg;
    logic [63:0]      a_ll_reg, b_ll_reg;
    logic [31:0]      a_cr_reg, b_cr_reg;
    logic [2:0]       ph_reg;
    logic [NB_W-1:0]  nb;
    logic [NB_W+31:0] plo_reg;
    logic [BLK_W-1:0] blk_reg;
    logic [31:0]      h32_reg;
    logic [4:0]       pos_reg [WORDS_PER_BLOCK];
    logic [ROW_W-1:0] mask;
    logic [ROW_W-1:0] row_reg;
    logic [31:0]      cnt_reg, cnt_next;
    logic [63:0]      a_x, b_x;
    logic [63:0]      mc;
    logic [63:0]      a_ll, b_ll;
    logic [31:0]      a_cr, b_cr;
    logic [63:0]      a_sum, b_sum;
    logic [NB_W+32:0] phi;
    logic [NB_W+32:0] blk_full;

    // effective block count: zero means one, large values saturate
    always_comb
    begin
        priority if (blocks_in_use == '0)
            nb = NB_W'(1);
        else if (blocks_in_use > CFG_W'(MAX_BLOCKS))
            nb = NB_W'(MAX_BLOCKS);
        else
            nb = NB_W'(blocks_in_use);
    end

    // xor-shift ahead of each finisher multiply
    always_comb
    begin
        unique case (ph_reg)
            3'd0:
            begin
                a_x = a_reg ^ (a_reg >> 30);
                b_x = b_reg ^ (b_reg >> 30);
                mc  = MIX_C1;
            end
            3'd2:
            begin
                a_x = a_reg ^ (a_reg >> 27);
                b_x = b_reg ^ (b_reg >> 27);
                mc  = MIX_C2;
            end
            default:
            begin
                a_x = a_reg;
                b_x = b_reg;
                mc  = MIX_C1;
            end
        endcase
    end

    // low 64 bits of a 64x64 product from 32x32 partial products
    assign a_ll  = {32'd0, a_x[31:0]} * {32'd0, mc[31:0]};
    assign b_ll  = {32'd0, b_x[31:0]} * {32'd0, mc[31:0]};
    assign a_cr  = a_x[31:0] * mc[63:32] + a_x[63:32] * mc[31:0];
    assign b_cr  = b_x[31:0] * mc[63:32] + b_x[63:32] * mc[31:0];
    assign a_sum = a_ll_reg + {a_cr_reg, 32'd0};
    assign b_sum = b_ll_reg + {b_cr_reg, 32'd0};

    assign phi      = (NB_W+33)'(a_reg[63:32]) * (NB_W+33)'(nb) + (NB_W+33)'(plo_reg >> 32);
    assign blk_full = phi >> 32;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= operation;
            a_reg  <= key_hash;
            b_reg  <= key_hash + GOLDEN;
            ph_reg <= '0;
        end
        else if (cmd.stage)
        begin
            ph_reg <= ph_reg + 3'd1;
            unique case (ph_reg)
                3'd0, 3'd2:
                begin
                    a_ll_reg <= a_ll;
                    a_cr_reg <= a_cr;
                    b_ll_reg <= b_ll;
                    b_cr_reg <= b_cr;
                end
                3'd1:
                begin
                    a_reg <= a_sum;
                    b_reg <= b_sum;
                end
                3'd3:
                begin
                    a_reg <= a_sum ^ (a_sum >> 31);
                    b_reg <= b_sum ^ (b_sum >> 31);
                end
                3'd4:
                begin
                    plo_reg <= (NB_W+32)'(a_reg[31:0]) * (NB_W+32)'(nb);
                    h32_reg <= b_reg[31:0] ^ b_reg[63:32];
                end
                3'd5:
                begin
                    if (blk_full >= (NB_W+33)'(MAX_BLOCKS))
                        blk_reg <= BLK_W'(MAX_BLOCKS - 1);
                    else
                        blk_reg <= blk_full[BLK_W-1:0];
                    for (int i = 0; i < WORDS_PER_BLOCK; i++)
                        pos_reg[i] <= 5'((h32_reg * SALT[i]) >> 27);
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        for (int i = 0; i < WORDS_PER_BLOCK; i++)
            mask[32*i +: 32] = 32'd1 << pos_reg[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_addr_reg <= '0;
        else if (cmd.clr_wr)
            clr_addr_reg <= clr_addr_reg + BLK_W'(1);
    end

    assign sts.clr_last = (clr_addr_reg == BLK_W'(MAX_BLOCKS - 1));

    // row memory: read the selected row, then write it back with the mask on insert
    always_ff @(posedge clk)
    begin
        if (cmd.clr_wr)
            mem[clr_addr_reg] <= '0;
        else if (cmd.mem_wr && op_reg == OP_INSERT)
            mem[blk_reg] <= row_reg | mask;
        if (cmd.mem_rd)
            row_reg <= mem[blk_reg];
    end

    assign cnt_next = (cnt_reg == 32'hffffffff) ? cnt_reg : cnt_reg + 32'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (cmd.out_load && op_reg == OP_INSERT)
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            chosen_block <= blk_reg;
            if (op_reg == OP_INSERT)
            begin
                maybe_present <= 1'b1;
                entry_count   <= cnt_next;
            end
            else
            begin
                maybe_present <= ((row_reg & mask) == mask);
                entry_count   <= cnt_reg;
            end
        end
    end

endmodule
`default_nettype wire

### hdl/split_block_bloom_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// split_block_bloom_filter
// split block bloom filter on pre-hashed 64-bit keys
// ----------------------------------------------------------------------------
// An accepted item passes through six steps through the two hash finishers
// (each 64-bit multiply is split into 32x32 partial products over two steps),
// block pick and salted multiplies, then one row read and one write-back, at
// which its result is registered. One item is in flight at a time, and a
// result not yet taken holds the next item in its write-back step. After
// reset a clearing pass zeroes the bit store, one 256-bit row a cycle, before
// the first item is accepted; configuration writes are taken throughout but
// should only change the block count between items.
module split_block_bloom_filter (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          cfg_valid,
    output logic                         cfg_ready,
    input  wire [sbbf_pkg::CFG_W-1:0]    cfg_data,
    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire                          operation,
    input  wire [63:0]                   key_hash,
    output logic                         out_valid,
    input  wire                          out_ready,
    output logic                         maybe_present,
    output logic [sbbf_pkg::BLK_W-1:0]   chosen_block,
    output logic [31:0]                  entry_count
);
    import sbbf_pkg::*;

    sbbf_cmd_t        cmd;
    sbbf_sts_t        sts;
    logic [CFG_W-1:0] blocks_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            blocks_reg <= CFG_W'(1024);
        else if (cfg_valid)
            blocks_reg <= cfg_data;
    end

    sbbf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    sbbf_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .blocks_in_use (blocks_reg),
        .operation     (operation),
        .key_hash      (key_hash),
        .maybe_present (maybe_present),
        .chosen_block  (chosen_block),
        .entry_count   (entry_count)
    );

endmodule
`default_nettype wire

### hdl/sbbf_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbbf_checker
// port-level checks for the split block bloom filter
// ----------------------------------------------------------------------------
module sbbf_checker (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        in_valid,
    input  wire        in_ready,
    input  wire        out_valid,
    input  wire        out_ready,
    input  wire        maybe_present,
    input  wire [31:0] entry_count,
    input  wire [9:0]  chosen_block
);
    // a taken item blocks the input until its result is out
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input ready right after an item");

    // no result appears the cycle after an item is taken
    a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !(out_valid && !$past(out_valid)))
        else $error("result too early");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(chosen_block)))
        else $error("result changed while stalled");

    // count and membership flag hold while a result waits
    a_fields_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> ($stable(entry_count) && $stable(maybe_present)))
        else $error("result fields changed while stalled");

endmodule

bind split_block_bloom_filter sbbf_checker u_sbbf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .maybe_present (maybe_present),
    .entry_count   (entry_count),
    .chosen_block  (chosen_block)
);
`default_nettype wire

### tb/sv/split_block_bloom_filter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// split_block_bloom_filter_tb
// drives inserts and queries with random pacing on both channels, predicts
// membership, block index and entry count from a local model of the bit store
// ----------------------------------------------------------------------------

class bloom_scoreboard;
    logic [31:0] bits [sbbf_pkg::MAX_BLOCKS*sbbf_pkg::WORDS_PER_BLOCK];
    logic [31:0] inserts;
    logic [10:0] blocks_cfg;
    logic        want_present [$];
    logic [9:0]  want_block [$];
    logic [31:0] want_count [$];
    int          errors;
    int          checked;
    int          hits;

    function new();
        foreach (bits[i]) bits[i] = '0;
        inserts    = '0;
        blocks_cfg = 11'd1024;
        errors     = 0;
        checked    = 0;
        hits       = 0;
    endfunction

    function logic [63:0] finish(logic [63:0] x);
        x = (x ^ (x >> 30)) * sbbf_pkg::MIX_C1;
        x = (x ^ (x >> 27)) * sbbf_pkg::MIX_C2;
        return x ^ (x >> 31);
    endfunction

    function void note_key(logic op, logic [63:0] key);
        logic [63:0] h1, h2;
        logic [31:0] n, h32, y, m;
        logic [95:0] prod;
        logic [31:0] blk;
        logic        all_set;
        h1 = finish(key);
        h2 = finish(key + sbbf_pkg::GOLDEN);
        n = {21'd0, blocks_cfg};
        if (n == 0) n = 1;
        if (n > sbbf_pkg::MAX_BLOCKS) n = sbbf_pkg::MAX_BLOCKS;
        prod = {32'd0, h1} * {64'd0, n};
        blk = prod[95:64];
        if (blk >= sbbf_pkg::MAX_BLOCKS) blk = sbbf_pkg::MAX_BLOCKS - 1;
        h32 = h2[31:0] ^ h2[63:32];
        all_set = 1'b1;
        for (int i = 0; i < sbbf_pkg::WORDS_PER_BLOCK; i++)
        begin
            y = h32 * sbbf_pkg::SALT[i];
            m = 32'd1 << y[31:27];
            if (op == sbbf_pkg::OP_QUERY)
            begin
                if ((bits[blk*8+i] & m) != m) all_set = 1'b0;
            end
            else
                bits[blk*8+i] |= m;
        end
        if (op == sbbf_pkg::OP_INSERT)
        begin
            if (inserts != 32'hffffffff) inserts++;
            all_set = 1'b1;
        end
        want_present.push_back(all_set);
        want_block.push_back(blk[9:0]);
        want_count.push_back(inserts);
    endfunction

    function int pending();
        return want_present.size();
    endfunction

    function void report(string what, logic [63:0] got, logic [63:0] exp);
        $display("mismatch on %s: got %0h, expected %0h", what, got, exp);
        errors++;
    endfunction

    function void check_result(logic present, logic [9:0] blk, logic [31:0] cnt);
        logic p_e;
        logic [9:0] b_e;
        logic [31:0] c_e;
        if (want_present.size() == 0)
        begin
            $display("result with nothing expected");
            errors++;
            return;
        end
        p_e = want_present.pop_front();
        b_e = want_block.pop_front();
        c_e = want_count.pop_front();
        checked++;
        if (present) hits++;
        if (present !== p_e) report("maybe_present", present, p_e);
        if (blk !== b_e) report("chosen_block", blk, b_e);
        if (cnt !== c_e) report("entry_count", cnt, c_e);
    endfunction
endclass

module split_block_bloom_filter_tb;
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [10:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        operation = 1'b0;
    logic [63:0] key_hash = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        maybe_present;
    logic [9:0]  chosen_block;
    logic [31:0] entry_count;

    bloom_scoreboard sb;
    logic [63:0] recent_keys [$];
    int          cycles = 0;
    bit          fast_sender = 0;
    bit          fast_receiver = 0;
    int          sent = 0;

    localparam int CYCLE_LIMIT = 400000;

    split_block_bloom_filter uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .operation(operation), .key_hash(key_hash),
        .out_valid(out_valid), .out_ready(out_ready),
        .maybe_present(maybe_present), .chosen_block(chosen_block),
        .entry_count(entry_count)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver with random stalls
    initial
    begin
        int wait_n;
        sb = new();
        forever
        begin
            @(posedge clk);
            if (out_ready && out_valid)
            begin
                sb.check_result(maybe_present, chosen_block, entry_count);
                wait_n = fast_receiver ? 0 : $urandom_range(0, 14);
                if (wait_n > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (wait_n) @(posedge clk);
                    out_ready <= 1'b1;
                end
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic write_blocks(logic [10:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.blocks_cfg = value;
    endtask

    task automatic drain();
        while (sb.pending() != 0) @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic send_key(logic op, logic [63:0] key);
        int gap;
        gap = fast_sender ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        key_hash  <= key;
        do @(posedge clk); while (!in_ready);
        sb.note_key(op, key);
        sent++;
        recent_keys.push_back(key);
        if (recent_keys.size() > 64) void'(recent_keys.pop_front());
    endtask

    task automatic end_burst();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [63:0] rand_key();
        return {$urandom(), $urandom()};
    endfunction

    initial
    begin
        logic [10:0] settings [6];
        logic [63:0] k;
        settings = '{11'd1, 11'd0, 11'd2047, 11'd1025, 11'd37, 11'd1024};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes of the hash, query before and after insert
        send_key(sbbf_pkg::OP_QUERY, 64'd0);
        send_key(sbbf_pkg::OP_INSERT, 64'd0);
        send_key(sbbf_pkg::OP_QUERY, 64'd0);
        send_key(sbbf_pkg::OP_INSERT, '1);
        send_key(sbbf_pkg::OP_QUERY, '1);
        send_key(sbbf_pkg::OP_QUERY, 64'h8000000000000000);
        send_key(sbbf_pkg::OP_INSERT, 64'h5555555555555555);
        send_key(sbbf_pkg::OP_QUERY, 64'haaaaaaaaaaaaaaaa);
        send_key(sbbf_pkg::OP_QUERY, 64'h61c8864680b583eb); // wraps with golden add
        end_burst();
        drain();

        for (int phase = 0; phase < 6; phase++)
        begin
            write_blocks(settings[phase]);
            fast_sender   = (phase == 2);
            fast_receiver = (phase == 2 || phase == 4);
            for (int i = 0; i < 200; i++)
            begin
                if (recent_keys.size() > 0 && $urandom_range(0, 2) == 0)
                    k = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
                else
                    k = rand_key();
                send_key(1'($urandom_range(0, 1)), k);
                // hold off until the block has drained
                if (i == 100)
                begin
                    end_burst();
                    drain();
                end
            end
            end_burst();
            drain();
        end

        $display("sent %0d keys over 6 block settings, %0d results checked, %0d present",
                 sent, sb.checked, sb.hits);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
